// ===== hw/rtl/pmq_pkg.sv =====
`timescale 1ns / 1ps
package pmq_pkg;

  localparam int ROOT_W = 16;
  localparam int IDX_W  = 4;
  localparam int REM_W  = 31;
  localparam int SUM_W  = 18;
  localparam int LANES  = 4;

  // Lane order inside the root chain
  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  localparam logic [ROOT_W-1:0] Q_ONE = 16'd16384;

  typedef struct packed {
    logic signed [15:0] rot_00;
    logic signed [15:0] rot_01;
    logic signed [15:0] rot_02;
    logic signed [15:0] rot_10;
    logic signed [15:0] rot_11;
    logic signed [15:0] rot_12;
    logic signed [15:0] rot_20;
    logic signed [15:0] rot_21;
    logic signed [15:0] rot_22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } pmq_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [14:0] quat_w;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
  } pmq_out_t;

  // Fields that ride along the root chain untouched
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
  } pmq_side_t;

  typedef struct packed {
    logic                               valid;
    logic [LANES-1:0][REM_W-1:0]        rem;
    logic [LANES-1:0][ROOT_W-1:0]       root;
    pmq_side_t                          side;
  } pmq_pipe_t;

endpackage

// ===== hw/rtl/pose_matrix_to_quaternion_top.sv =====
`timescale 1ns / 1ps
// Pipeline: a request taken by start passes the prep register, 16 square-root cells
// and the finish register before out_valid rises with the result.
// Throughput: one request per cycle; busy is always low, every cell is pipelined.
// Reset (synchronous, rst_n low) clears the valid bits of every stage; data
// registers are not reset. The receiver cannot stall: each result shows once.
module pose_matrix_to_quaternion_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pmq_pkg::pmq_in_t  in_data,
  output logic              out_valid,
  output pmq_pkg::pmq_out_t out_data
);
  import pmq_pkg::*;

  pmq_pipe_t chain [0:ROOT_W];

  assign busy = 1'b0;

  pmq_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (start && !busy),
    .req    (in_data),
    .pipe_o (chain[0])
  );

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    pmq_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_bit (IDX_W'(ROOT_W - 1 - k)),
      .pipe_i    (chain[k]),
      .pipe_o    (chain[k+1])
    );
  end

  pmq_finish u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .pipe_i  (chain[ROOT_W]),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

endmodule

// ===== hw/rtl/pmq_prep.sv =====
`timescale 1ns / 1ps
module pmq_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  pmq_pkg::pmq_in_t  req,
  output pmq_pkg::pmq_pipe_t pipe_o
);
  import pmq_pkg::*;

  logic signed [SUM_W-1:0] m00, m11, m22, one;
  logic signed [SUM_W-1:0] s_w, s_x, s_y, s_z;
  logic [LANES-1:0][REM_W-1:0] rad;
  pmq_side_t side;
  logic valid_r;
  logic [LANES-1:0][REM_W-1:0] rem_r;
  pmq_side_t side_r;

  function automatic logic [REM_W-1:0] to_rad(input logic signed [SUM_W-1:0] s);
    logic [REM_W-1:0] r;
    // drop non-positive sums, scale by 2^14 otherwise
    if (s[SUM_W-1] || s == '0) r = '0;
    else r = {s[SUM_W-2:0], 14'd0};
    return r;
  endfunction

  always_comb begin
    m00 = SUM_W'(req.rot_00);
    m11 = SUM_W'(req.rot_11);
    m22 = SUM_W'(req.rot_22);
    one = SUM_W'(Q_ONE);
    s_w = one + m00 + m11 + m22;
    s_x = one + m00 - m11 - m22;
    s_y = one - m00 + m11 - m22;
    s_z = one - m00 - m11 + m22;
    rad[LANE_W] = to_rad(s_w);
    rad[LANE_X] = to_rad(s_x);
    rad[LANE_Y] = to_rad(s_y);
    rad[LANE_Z] = to_rad(s_z);

    if (req.trans_x == 32'sh8000_0000) side.pos_x = 32'sh7fff_ffff;
    else side.pos_x = -req.trans_x;
    side.pos_y = req.trans_z;
    side.pos_z = req.trans_y;
    side.neg_x = req.rot_21 < req.rot_12;
    side.neg_y = req.rot_02 < req.rot_20;
    side.neg_z = req.rot_10 < req.rot_01;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= take;
  end

  always_ff @(posedge clk) begin
    rem_r  <= rad;
    side_r <= side;
  end

  always_comb begin
    pipe_o.valid = valid_r;
    pipe_o.rem   = rem_r;
    pipe_o.root  = '0;
    pipe_o.side  = side_r;
  end

endmodule

// ===== hw/rtl/pmq_sqrt_cell.sv =====
`timescale 1ns / 1ps
module pmq_sqrt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [pmq_pkg::IDX_W-1:0] stage_bit,
  input  pmq_pkg::pmq_pipe_t       pipe_i,
  output pmq_pkg::pmq_pipe_t       pipe_o
);
  import pmq_pkg::*;

  pmq_pipe_t pipe_nxt, pipe_r;
  logic [LANES-1:0][REM_W+1:0] trial;

  // One root bit per lane: try setting it, keep it if the remainder allows
  always_comb begin
    pipe_nxt = pipe_i;
    for (int l = 0; l < LANES; l++) begin
      trial[l] = ({(REM_W+2-ROOT_W)'(0), pipe_i.root[l]} << ({1'b0, stage_bit} + 5'd1))
               | ((REM_W+2)'(1) << ({1'b0, stage_bit} << 1));
      if ({2'b00, pipe_i.rem[l]} >= trial[l]) begin
        pipe_nxt.rem[l]  = pipe_i.rem[l] - trial[l][REM_W-1:0];
        pipe_nxt.root[l] = pipe_i.root[l] | (ROOT_W'(1) << stage_bit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pipe_r.valid <= 1'b0;
    else pipe_r.valid <= pipe_nxt.valid;
    pipe_r.rem  <= pipe_nxt.rem;
    pipe_r.root <= pipe_nxt.root;
    pipe_r.side <= pipe_nxt.side;
  end

  assign pipe_o = pipe_r;

endmodule

// ===== hw/rtl/pmq_finish.sv =====
`timescale 1ns / 1ps
module pmq_finish (
  input  logic               clk,
  input  logic               rst_n,
  input  pmq_pkg::pmq_pipe_t pipe_i,
  output logic               valid_o,
  output pmq_pkg::pmq_out_t  data_o
);
  import pmq_pkg::*;

  logic [LANES-1:0][14:0] mag;
  logic [ROOT_W:0] rnd;
  pmq_out_t data_nxt, data_r;
  logic valid_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // round half up, then saturate at one
      rnd = ({1'b0, pipe_i.root[l]} + (ROOT_W+1)'(1)) >> 1;
      if (rnd > {1'b0, Q_ONE}) mag[l] = Q_ONE[14:0];
      else mag[l] = rnd[14:0];
    end
    data_nxt.pos_x  = pipe_i.side.pos_x;
    data_nxt.pos_y  = pipe_i.side.pos_y;
    data_nxt.pos_z  = pipe_i.side.pos_z;
    data_nxt.quat_w = mag[LANE_W];
    data_nxt.quat_i = pipe_i.side.neg_x ? -$signed({1'b0, mag[LANE_X]})
                                        :  $signed({1'b0, mag[LANE_X]});
    data_nxt.quat_j = pipe_i.side.neg_z ?  $signed({1'b0, mag[LANE_Z]})
                                        : -$signed({1'b0, mag[LANE_Z]});
    data_nxt.quat_k = pipe_i.side.neg_y ? -$signed({1'b0, mag[LANE_Y]})
                                        :  $signed({1'b0, mag[LANE_Y]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= pipe_i.valid;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule
